FILE: rtl/core/wcts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcts_pkg
// Shared constants, register indexes and the control/status bundles of the
// windowed cycle time sensor core.
// ----------------------------------------------------------------------------
package wcts_pkg;

    localparam int TIME_BITS_DEF  = 48;
    localparam int SCALE_BITS     = 32;
    localparam int FRAC_BITS      = 17;
    localparam int FRAC_STEPS     = 16;
    localparam int CFG_INDEX_BITS = 3;

    localparam logic [FRAC_BITS-1:0] FRAC_ONE = 17'h10000;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ENABLE       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_FORWARD  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_START_TIME   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_TIME    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CYCLE_LENGTH = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TIME_SCALE   = 3'd5;

    localparam logic [SCALE_BITS-1:0] TIME_SCALE_RST   = 32'h0001_0000;
    localparam int                    CYCLE_LENGTH_RST = 65536;

    typedef struct packed {
        logic load;
        logic eval;
        logic mul_lo;
        logic mul_hi;
        logic round;
        logic sum;
        logic mod_step;
        logic fixup;
        logic frac_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic adv;
        logic out_free;
    } status_t;

endpackage

FILE: rtl/core/wcts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcts_ctrl
// Sequencer: evaluates each accepted frame word and, if it advances the phase,
// steps the datapath through multiply, round, sum, modulo, fixup and fraction.
// ----------------------------------------------------------------------------
module wcts_ctrl #(
    parameter int TIME_BITS = wcts_pkg::TIME_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             frame_valid,
    output logic             frame_stall,
    input  wcts_pkg::status_t status,
    output wcts_pkg::cmd_t    cmd
);

    localparam int Y_W   = TIME_BITS + 17;
    localparam int CNT_W = $clog2(Y_W);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_EVAL   = 10'b00_0000_0010,
        S_MUL_LO = 10'b00_0000_0100,
        S_MUL_HI = 10'b00_0000_1000,
        S_ROUND  = 10'b00_0001_0000,
        S_SUM    = 10'b00_0010_0000,
        S_MOD    = 10'b00_0100_0000,
        S_FIXUP  = 10'b00_1000_0000,
        S_FRAC   = 10'b01_0000_0000,
        S_FINISH = 10'b10_0000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign frame_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (frame_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.adv ? S_MUL_LO : S_FINISH;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                cnt_next   = CNT_W'(Y_W - 1);
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIXUP;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_FIXUP:
            begin
                cmd.fixup  = 1'b1;
                cnt_next   = CNT_W'(wcts_pkg::FRAC_STEPS - 1);
                state_next = S_FRAC;
            end
            S_FRAC:
            begin
                cmd.frac_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/wcts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcts_datapath
// Configuration registers, sensor state, split 64x32 multiply, restoring
// remainder unit shared by the modulo and fraction steps, output register.
// ----------------------------------------------------------------------------
module wcts_datapath #(
    parameter int TIME_BITS = wcts_pkg::TIME_BITS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write_en,
    input  logic [wcts_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [TIME_BITS-1:0]                     cfg_data,
    input  logic [TIME_BITS-1:0]                     frame_time,
    input  wcts_pkg::cmd_t                           cmd,
    output wcts_pkg::status_t                        status,
    output logic                                     result_valid,
    input  logic                                     result_stall,
    output logic [TIME_BITS-1:0]                     phase_time,
    output logic [wcts_pkg::FRAC_BITS-1:0]           cycle_fraction,
    output logic                                     running
);

    localparam int PROD_W = TIME_BITS + 32;
    localparam int P_W    = PROD_W - 16;
    localparam int Y_W    = P_W + 1;
    localparam int SB     = wcts_pkg::SCALE_BITS;
    localparam int FB     = wcts_pkg::FRAC_BITS;

    // configuration
    logic                 enable_reg;
    logic                 run_forward_reg;
    logic [TIME_BITS-1:0] start_time_reg;
    logic [TIME_BITS-1:0] stop_time_reg;
    logic [TIME_BITS-1:0] cycle_length_reg;
    logic [SB-1:0]        time_scale_reg;

    // sensor state
    logic [TIME_BITS-1:0] last_time_reg;
    logic [TIME_BITS-1:0] phase_reg;
    logic [FB-1:0]        fraction_reg;
    logic                 active_reg;

    // work registers
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] prev_reg;
    logic [TIME_BITS-1:0] mag_reg;
    logic [SB-1:0]        kmag_reg;
    logic                 neg_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [P_W-1:0]       p_reg;
    logic [Y_W-1:0]       y_reg;
    logic                 wrap_reg;
    logic [TIME_BITS-1:0] rem_reg;

    // output register
    logic                 result_valid_reg;
    logic [TIME_BITS-1:0] phase_time_reg;
    logic [FB-1:0]        cycle_fraction_reg;
    logic                 running_reg;

    // evaluate
    logic                 len_zero;
    logic                 before_start;
    logic                 after_stop;
    logic                 prev_after_stop;
    logic [TIME_BITS-1:0] base;
    logic [TIME_BITS:0]   diff_nb;
    logic [TIME_BITS:0]   diff_bn;
    logic                 now_ge_base;
    logic                 scale_neg;
    logic [SB-1:0]        kmag;
    logic                 park_fwd_end;
    logic                 park_bwd_end;

    // multiply
    logic [63:0]          mag64;
    logic [63:0]          lo_prod;
    logic [63:0]          hi_prod;
    logic [95:0]          hi_shift;

    // round and sum
    logic                 round_up;
    logic [P_W-1:0]       phase_p;
    logic                 p_le_phase;
    logic [Y_W-1:0]       y_val;

    // remainder unit
    logic                 step_bit;
    logic [TIME_BITS:0]   step_t;
    logic                 step_ge;
    logic [TIME_BITS:0]   step_sub;
    logic [TIME_BITS-1:0] step_rem;
    logic [TIME_BITS-1:0] fix_rem;

    assign len_zero        = (cycle_length_reg == '0);
    assign before_start    = (now_reg < start_time_reg);
    assign after_stop      = (start_time_reg < stop_time_reg) && (now_reg > stop_time_reg);
    assign prev_after_stop = (prev_reg > stop_time_reg);
    assign base            = (prev_reg == '0) ? start_time_reg : prev_reg;
    assign diff_nb         = {1'b0, now_reg} - {1'b0, base};
    assign diff_bn         = {1'b0, base} - {1'b0, now_reg};
    assign now_ge_base     = !diff_nb[TIME_BITS];
    assign scale_neg       = time_scale_reg[SB-1];
    assign kmag            = scale_neg ? (SB'(0) - time_scale_reg) : time_scale_reg;
    assign park_fwd_end    = run_forward_reg && !len_zero;
    assign park_bwd_end    = !run_forward_reg && !len_zero;

    assign status.adv      = enable_reg && !before_start && !after_stop && !len_zero;
    assign status.out_free = !result_valid_reg || !result_stall;

    assign mag64    = 64'(mag_reg);
    assign lo_prod  = 64'(mag64[31:0]) * 64'(kmag_reg);
    assign hi_prod  = 64'(mag64[63:32]) * 64'(kmag_reg);
    assign hi_shift = {hi_prod, 32'b0};

    assign round_up   = neg_reg && (acc_reg[15:0] != '0);
    assign phase_p    = P_W'(phase_reg);
    assign p_le_phase = (p_reg <= phase_p);

    always_comb
    begin
        if (!neg_reg)
        begin
            y_val = Y_W'(phase_p) + Y_W'(p_reg);
        end
        else if (p_le_phase)
        begin
            y_val = Y_W'(phase_p - p_reg);
        end
        else
        begin
            y_val = Y_W'(p_reg - phase_p);
        end
    end

    assign step_bit = cmd.mod_step ? y_reg[Y_W-1] : 1'b0;
    assign step_t   = {rem_reg, step_bit};
    assign step_ge  = (step_t >= {1'b0, cycle_length_reg});
    assign step_sub = step_t - {1'b0, cycle_length_reg};
    assign step_rem = step_ge ? step_sub[TIME_BITS-1:0] : step_t[TIME_BITS-1:0];
    assign fix_rem  = (wrap_reg && (rem_reg != '0)) ? (cycle_length_reg - rem_reg) : rem_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b1;
            run_forward_reg  <= 1'b1;
            start_time_reg   <= '0;
            stop_time_reg    <= '0;
            cycle_length_reg <= TIME_BITS'(wcts_pkg::CYCLE_LENGTH_RST);
            time_scale_reg   <= wcts_pkg::TIME_SCALE_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                wcts_pkg::REG_ENABLE:       enable_reg       <= cfg_data[0];
                wcts_pkg::REG_RUN_FORWARD:  run_forward_reg  <= cfg_data[0];
                wcts_pkg::REG_START_TIME:   start_time_reg   <= cfg_data;
                wcts_pkg::REG_STOP_TIME:    stop_time_reg    <= cfg_data;
                wcts_pkg::REG_CYCLE_LENGTH: cycle_length_reg <= cfg_data;
                wcts_pkg::REG_TIME_SCALE:   time_scale_reg   <= cfg_data[SB-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sensor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            phase_reg     <= '0;
            fraction_reg  <= '0;
            active_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                last_time_reg <= frame_time;
            end
            if (cmd.eval)
            begin
                if (!enable_reg)
                begin
                    active_reg <= 1'b0;
                end
                else if (before_start)
                begin
                    if (active_reg)
                    begin
                        phase_reg    <= park_bwd_end ? cycle_length_reg : '0;
                        fraction_reg <= park_bwd_end ? wcts_pkg::FRAC_ONE : '0;
                        active_reg   <= 1'b0;
                    end
                end
                else if (after_stop)
                begin
                    if (active_reg)
                    begin
                        phase_reg    <= park_fwd_end ? cycle_length_reg : '0;
                        fraction_reg <= park_fwd_end ? wcts_pkg::FRAC_ONE : '0;
                        if (prev_after_stop)
                        begin
                            active_reg <= 1'b0;
                        end
                    end
                end
                else if (len_zero)
                begin
                    phase_reg    <= '0;
                    fraction_reg <= '0;
                end
            end
            if (cmd.fixup)
            begin
                phase_reg  <= fix_rem;
                active_reg <= 1'b1;
            end
            if (cmd.frac_step)
            begin
                fraction_reg <= {1'b0, fraction_reg[FB-3:0], step_ge};
            end
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            now_reg  <= frame_time;
            prev_reg <= last_time_reg;
        end
        if (cmd.eval)
        begin
            mag_reg  <= now_ge_base ? diff_nb[TIME_BITS-1:0] : diff_bn[TIME_BITS-1:0];
            neg_reg  <= !now_ge_base ^ scale_neg ^ !run_forward_reg;
            kmag_reg <= kmag;
        end
        if (cmd.mul_lo)
        begin
            acc_reg <= PROD_W'(lo_prod);
        end
        if (cmd.mul_hi)
        begin
            acc_reg <= acc_reg + hi_shift[PROD_W-1:0];
        end
        if (cmd.round)
        begin
            p_reg <= acc_reg[PROD_W-1:16] + P_W'(round_up);
        end
        if (cmd.sum)
        begin
            y_reg    <= y_val;
            wrap_reg <= neg_reg && !p_le_phase;
            rem_reg  <= '0;
        end
        if (cmd.mod_step)
        begin
            y_reg   <= {y_reg[Y_W-2:0], 1'b0};
            rem_reg <= step_rem;
        end
        if (cmd.fixup)
        begin
            rem_reg <= fix_rem;
        end
        if (cmd.frac_step)
        begin
            rem_reg <= step_rem;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            phase_time_reg     <= phase_reg;
            cycle_fraction_reg <= fraction_reg;
            running_reg        <= active_reg;
        end
    end

    assign result_valid   = result_valid_reg;
    assign phase_time     = phase_time_reg;
    assign cycle_fraction = cycle_fraction_reg;
    assign running        = running_reg;

endmodule

FILE: rtl/core/windowed_cycle_time_sensor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_cycle_time_sensor_core
// Frame-driven cycle timer: windowed phase advance, modulo and fraction.
// ----------------------------------------------------------------------------
// a frame word that moves the phase runs the multiply, round, sum, modulo,
// fixup and fraction steps; a frame that does not goes straight to the result
// no new frame word is taken until the current result is emitted; the
// remainder unit works one bit a cycle on the modulo and the 16 fraction steps
// the result register lets a new frame in while a result word is stalled
// reset: async active low; config and sensor state return to defaults
module windowed_cycle_time_sensor_core #(
    parameter int TIME_BITS = wcts_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [wcts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [TIME_BITS-1:0]                cfg_data,
    input  logic                                frame_valid,
    output logic                                frame_stall,
    input  logic [TIME_BITS-1:0]                frame_time,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [TIME_BITS-1:0]                phase_time,
    output logic [wcts_pkg::FRAC_BITS-1:0]      cycle_fraction,
    output logic                                running
);

    wcts_pkg::cmd_t    cmd;
    wcts_pkg::status_t status;

    wcts_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .status      (status),
        .cmd         (cmd)
    );

    wcts_datapath #(
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .frame_time     (frame_time),
        .cmd            (cmd),
        .status         (status),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .phase_time     (phase_time),
        .cycle_fraction (cycle_fraction),
        .running        (running)
    );

endmodule
